@@ rtl/rthp_pkg.sv @@
package rthp_pkg;

  // Channel width of every input and result field.
  localparam int unsigned CH_BITS = 8;
  localparam logic [CH_BITS-1:0] CH_MAX = {CH_BITS{1'b1}};

  // Hue numerator before scaling lies in 0 .. 6*M-1.
  localparam int unsigned HN_W  = CH_BITS + 3;
  // Dividend (M * something) and divisor widths shared by both dividers.
  localparam int unsigned NUM_W = 2 * CH_BITS + 3;
  localparam int unsigned DEN_W = CH_BITS + 3;

  // Register after the max/min/sextant stage.
  typedef struct packed {
    logic [HN_W-1:0]    hnum;
    logic [CH_BITS-1:0] d;
    logic [CH_BITS-1:0] sden;
    logic [CH_BITS-1:0] lum;
  } sa_t;

  // One stage of the two restoring dividers.
  typedef struct packed {
    logic [NUM_W-1:0]   hrem;
    logic [DEN_W-1:0]   hden;
    logic [NUM_W-1:0]   srem;
    logic [DEN_W-1:0]   sden;
    logic [CH_BITS-1:0] hq;
    logic [CH_BITS-1:0] sq;
    logic [CH_BITS-1:0] lum;
  } dv_t;

endpackage

@@ rtl/rthp_if.sv @@
interface rthp_in_if;
  import rthp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] red;
  logic [CH_BITS-1:0] green;
  logic [CH_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthp_out_if;
  import rthp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] hue;
  logic [CH_BITS-1:0] saturation;
  logic [CH_BITS-1:0] luminance;

  modport source (output valid, output hue, output saturation, output luminance,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input luminance,
                  output ready);
endinterface

@@ rtl/rgb_to_hsl_pixel_unit.sv @@
// RGB to HSL converter, one pixel per transaction.
// Path to output valid: stage A register, stage B register, then the divider stage registers.
// Throughput: one pixel per cycle while the output is not stalled; the two dividers resolve one quotient bit per stage.
// The whole pipeline holds while the output register is full and not taken.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data is not reset.
module rgb_to_hsl_pixel_unit
  import rthp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rthp_in_if.sink    pix_i,
  rthp_out_if.source hsl_o
);

  logic adv;

  // ---------------- stage A: max, min, sextant, saturation divisor
  sa_t  sa_d, sa_q;
  logic va_q;

  logic [CH_BITS-1:0]      r, g, b, mx, mn, d;
  logic [CH_BITS:0]        sum, sden_full;
  logic signed [CH_BITS+3:0] rs, gs, bs, sd, num;

  always_comb begin
    r  = pix_i.red;
    g  = pix_i.green;
    b  = pix_i.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    d  = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    rs = signed'({4'b0000, r});
    gs = signed'({4'b0000, g});
    bs = signed'({4'b0000, b});
    sd = signed'({4'b0000, d});
    // red wins ties over green and blue, green over blue
    if (r == mx) begin
      num = gs - bs;
    end else if (g == mx) begin
      num = (sd <<< 1) + bs - rs;
    end else begin
      num = (sd <<< 2) + rs - gs;
    end
    if (num < 0) begin
      num = num + (sd <<< 2) + (sd <<< 1);
    end
    if (sum < {1'b0, CH_MAX}) begin
      sden_full = sum;
    end else begin
      sden_full = {CH_MAX, 1'b0} - sum;
    end
    sa_d.hnum = num[HN_W-1:0];
    sa_d.d    = d;
    // grey pixel: divisor 1 with zero dividend gives zero quotient
    sa_d.sden = (d == '0) ? CH_BITS'(1) : sden_full[CH_BITS-1:0];
    sa_d.lum  = sum[CH_BITS:1];
  end

  // ---------------- stage B: scale dividends by full scale
  dv_t pipe_d [CH_BITS+1];
  dv_t pipe_q [CH_BITS+1];
  logic [CH_BITS:0] pv_q;

  logic [NUM_W-1:0] hn_ext, d_ext;
  logic [DEN_W-1:0] d_den;

  always_comb begin
    hn_ext = NUM_W'(sa_q.hnum);
    d_ext  = NUM_W'(sa_q.d);
    d_den  = DEN_W'(sa_q.d);
    // M * x computed as (x << CH_BITS) - x
    pipe_d[0].hrem = (hn_ext << CH_BITS) - hn_ext;
    pipe_d[0].srem = (d_ext << CH_BITS) - d_ext;
    pipe_d[0].hden = (sa_q.d == '0) ? DEN_W'(1) : (d_den << 2) + (d_den << 1);
    pipe_d[0].sden = DEN_W'(sa_q.sden);
    pipe_d[0].hq   = '0;
    pipe_d[0].sq   = '0;
    pipe_d[0].lum  = sa_q.lum;
  end

  // ---------------- divider stages, MSB of the quotient first
  for (genvar j = 0; j < CH_BITS; j++) begin : g_div
    localparam int unsigned Sh = CH_BITS - 1 - j;
    logic [NUM_W-1:0] hsh, ssh;
    logic             hbit, sbit;

    always_comb begin
      hsh  = NUM_W'(pipe_q[j].hden) << Sh;
      ssh  = NUM_W'(pipe_q[j].sden) << Sh;
      hbit = (pipe_q[j].hrem >= hsh);
      sbit = (pipe_q[j].srem >= ssh);
      pipe_d[j+1]      = pipe_q[j];
      pipe_d[j+1].hrem = hbit ? pipe_q[j].hrem - hsh : pipe_q[j].hrem;
      pipe_d[j+1].srem = sbit ? pipe_q[j].srem - ssh : pipe_q[j].srem;
      pipe_d[j+1].hq   = {pipe_q[j].hq[CH_BITS-2:0], hbit};
      pipe_d[j+1].sq   = {pipe_q[j].sq[CH_BITS-2:0], sbit};
    end
  end

  // ---------------- handshake: all stages advance together
  assign adv         = ~pv_q[CH_BITS] | hsl_o.ready;
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      pv_q <= '0;
    end else if (adv) begin
      va_q <= pix_i.valid;
      pv_q <= {pv_q[CH_BITS-1:0], va_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q <= sa_d;
      for (int k = 0; k <= CH_BITS; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign hsl_o.valid      = pv_q[CH_BITS];
  assign hsl_o.hue        = pipe_q[CH_BITS].hq;
  assign hsl_o.saturation = pipe_q[CH_BITS].sq;
  assign hsl_o.luminance  = pipe_q[CH_BITS].lum;

endmodule
